/* hdl/kwm_pkg.sv */
// Shared types, codes and default sizes for the k-way sorted merge block.
`default_nettype none
package kwm_pkg;

    localparam int LIST_COUNT_DEF       = 16;
    localparam int ELEMENT_CAPACITY_DEF = 64;
    localparam int VALUE_WIDTH_DEF      = 32;

    localparam logic K_LOAD = 1'b0;
    localparam logic K_END  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [3:0]         list_id;
        logic signed [31:0] element_value;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic [3:0]         source_list;
        logic               is_last;
        logic               overflowed;
    } t_result;

endpackage
`default_nettype wire

/* hdl/k_way_sorted_merge.sv */
// Top level of the k-way sorted merge block: request queue plus merge engine.
// Usage: a request is taken at a rising edge where start is high and busy is low.
// A load request (kind 0) appends element_value to the tail of list list_id in a
// shared element store of ELEMENT_CAPACITY entries; loads past capacity are dropped
// and mark every result of the next run as overflowed. Loads to a list number at or
// above LIST_COUNT are ignored. An end request (kind 1) starts the merge: every
// stored element is sent out in ascending signed order (ties to the lower list),
// with its source list and a last mark on the final one. An end request with
// nothing stored gives no result. Afterwards all lists are empty again.
// A load to a list that already holds elements passes through a link state.
// For each result the engine scans every list head through the head and element
// memories (one list per cycle, two read stages), then reads the chosen element's
// link. A two-entry queue decouples the request port from the engine; busy is
// high while that queue is full. Results appear on o_result for one cycle with
// o_strobe high; the receiver cannot stall them. Synchronous active-low reset
// empties the queue and all lists.
`default_nettype none
module k_way_sorted_merge #(
    parameter int LIST_COUNT       = kwm_pkg::LIST_COUNT_DEF,
    parameter int ELEMENT_CAPACITY = kwm_pkg::ELEMENT_CAPACITY_DEF,
    parameter int VALUE_WIDTH      = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire kwm_pkg::t_in_req i_req,
    output logic                  o_strobe,
    output kwm_pkg::t_result      o_result
);
    import kwm_pkg::*;

    // Queue head handed from the intake side to the engine.
    logic    q_valid;
    t_in_req q_req;
    logic    q_pop;

    kwm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_q_valid (q_valid),
        .o_q_req   (q_req),
        .i_q_pop   (q_pop)
    );

    kwm_back #(
        .LIST_COUNT       (LIST_COUNT),
        .ELEMENT_CAPACITY (ELEMENT_CAPACITY),
        .VALUE_WIDTH      (VALUE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_req   (q_req),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

/* hdl/kwm_front.sv */
// Request intake: a two-entry queue between the command port and the merge engine.
`default_nettype none
module kwm_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire kwm_pkg::t_in_req i_req,
    output logic                 o_q_valid,
    output kwm_pkg::t_in_req     o_q_req,
    input  wire logic            i_q_pop
);
    import kwm_pkg::*;

    t_in_req    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign busy      = (r_cnt == 2'd2);
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

/* hdl/kwm_back.sv */
// Merge engine: linked per-list element store and a repeated minimum scan over list heads.
`default_nettype none
module kwm_back #(
    parameter int LIST_COUNT       = kwm_pkg::LIST_COUNT_DEF,
    parameter int ELEMENT_CAPACITY = kwm_pkg::ELEMENT_CAPACITY_DEF,
    parameter int VALUE_WIDTH      = kwm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire kwm_pkg::t_in_req i_q_req,
    output logic                  o_q_pop,
    output logic                  o_strobe,
    output kwm_pkg::t_result      o_result
);
    import kwm_pkg::*;

    localparam int AW = (ELEMENT_CAPACITY > 1) ? $clog2(ELEMENT_CAPACITY) : 1;
    localparam int IW = $clog2(ELEMENT_CAPACITY + 1);
    localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int SW = $clog2(LIST_COUNT + 1);
    localparam logic [IW-1:0] NONE = IW'(ELEMENT_CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LINK = 5'b00010,
        S_SCAN = 5'b00100,
        S_ADV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    logic signed [VALUE_WIDTH-1:0] store_mem [ELEMENT_CAPACITY];
    logic [IW-1:0]                 link_mem  [ELEMENT_CAPACITY];
    logic [AW-1:0]                 head_mem  [LIST_COUNT];
    logic [AW-1:0]                 tail_mem  [LIST_COUNT];

    t_state                r_state;
    logic [LIST_COUNT-1:0] r_ne;
    logic [IW-1:0]         r_count;
    logic [IW-1:0]         r_emit;
    logic                  r_drop;
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_t_rd;
    logic [AW-1:0]         r_h_rd;
    logic signed [VALUE_WIDTH-1:0] r_v_rd;
    logic [IW-1:0]         r_k_rd;

    logic [SW-1:0]         r_scan;
    logic                  r_p1_go, r_p1_v, r_p1_last;
    logic [LW-1:0]         r_p1_l;
    logic                  r_p2_go, r_p2_v, r_p2_last;
    logic [LW-1:0]         r_p2_l;
    logic [AW-1:0]         r_p2_h;
    logic                  r_bf;
    logic signed [VALUE_WIDTH-1:0] r_best_val;
    logic [LW-1:0]         r_best_list;
    logic [AW-1:0]         r_best_head;

    logic                  r_out_stb;
    t_result               r_out;

    logic          in_range;
    logic [LW-1:0] ld_list;
    logic          full;
    logic          ld_go;
    logic          nxt_valid;
    logic          is_last;
    logic signed [VALUE_WIDTH-1:0] ld_key;

    assign in_range  = (32'(i_q_req.list_id) < 32'(LIST_COUNT));
    assign ld_list   = LW'(i_q_req.list_id);
    assign full      = (r_count >= NONE);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign ld_go     = o_q_pop && (i_q_req.kind == K_LOAD) && in_range && !full;
    assign nxt_valid = (r_k_rd < NONE);
    assign is_last   = (IW'(r_emit + 1'b1) == r_count);
    assign ld_key    = VALUE_WIDTH'(i_q_req.element_value);
    assign o_strobe  = r_out_stb;
    assign o_result  = r_out;

    // Element store and links: written on loads, read during the scan and the advance.
    always_ff @(posedge i_clk) begin
        if (ld_go) begin
            store_mem[r_count[AW-1:0]] <= ld_key;
        end
        r_v_rd <= store_mem[r_h_rd];
    end

    always_ff @(posedge i_clk) begin
        if (ld_go) begin
            link_mem[r_count[AW-1:0]] <= NONE;
        end else if (r_state == S_LINK) begin
            link_mem[r_t_rd] <= IW'(r_idx);
        end
        r_k_rd <= link_mem[r_best_head];
    end

    always_ff @(posedge i_clk) begin
        if (ld_go && !r_ne[ld_list]) begin
            head_mem[ld_list] <= r_count[AW-1:0];
        end else if (r_state == S_EMIT && nxt_valid) begin
            head_mem[r_best_list] <= r_k_rd[AW-1:0];
        end
        r_h_rd <= head_mem[r_scan[LW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ld_go) begin
            tail_mem[ld_list] <= r_count[AW-1:0];
        end
        r_t_rd <= tail_mem[ld_list];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ne      <= '0;
            r_count   <= '0;
            r_emit    <= '0;
            r_drop    <= 1'b0;
            r_scan    <= '0;
            r_p1_go   <= 1'b0;
            r_p2_go   <= 1'b0;
            r_bf      <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_out_stb <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_req.kind == K_LOAD) begin
                            if (in_range) begin
                                if (full) begin
                                    r_drop <= 1'b1;
                                end else begin
                                    r_ne[ld_list] <= 1'b1;
                                    r_idx         <= r_count[AW-1:0];
                                    r_count       <= IW'(r_count + 1'b1);
                                    if (r_ne[ld_list]) begin
                                        r_state <= S_LINK;
                                    end
                                end
                            end
                        end else if (|r_ne) begin
                            r_emit  <= '0;
                            r_scan  <= '0;
                            r_bf    <= 1'b0;
                            r_p1_go <= 1'b0;
                            r_p2_go <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                        end
                    end
                end
                S_LINK: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    // Stage 0 reads a list head, stage 1 its value, stage 2 compares.
                    if (32'(r_scan) < 32'(LIST_COUNT)) begin
                        r_scan    <= SW'(r_scan + 1'b1);
                        r_p1_go   <= 1'b1;
                        r_p1_v    <= r_ne[r_scan[LW-1:0]];
                        r_p1_l    <= r_scan[LW-1:0];
                        r_p1_last <= (32'(r_scan) == 32'(LIST_COUNT - 1));
                    end else begin
                        r_p1_go <= 1'b0;
                    end
                    r_p2_go   <= r_p1_go;
                    r_p2_v    <= r_p1_v;
                    r_p2_l    <= r_p1_l;
                    r_p2_h    <= r_h_rd;
                    r_p2_last <= r_p1_last;
                    if (r_p2_go && r_p2_v && (!r_bf || r_v_rd < r_best_val)) begin
                        r_bf        <= 1'b1;
                        r_best_val  <= r_v_rd;
                        r_best_list <= r_p2_l;
                        r_best_head <= r_p2_h;
                    end
                    if (r_p2_go && r_p2_last) begin
                        r_p1_go <= 1'b0;
                        r_p2_go <= 1'b0;
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_out_stb          <= 1'b1;
                    r_out.merged_value <= 32'(r_best_val);
                    r_out.source_list  <= 4'(r_best_list);
                    r_out.is_last      <= is_last;
                    r_out.overflowed   <= r_drop;
                    r_emit             <= IW'(r_emit + 1'b1);
                    if (!nxt_valid) begin
                        r_ne[r_best_list] <= 1'b0;
                    end
                    if (is_last) begin
                        r_ne    <= '0;
                        r_count <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_scan  <= '0;
                        r_bf    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the k-way sorted merge block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import kwm_pkg::*;

    localparam int NUM_LISTS = 16;
    localparam int CAPACITY  = 64;
    localparam int NO_ELEM   = CAPACITY;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_in_req i_req;
    logic    o_strobe;
    t_result o_result;

    k_way_sorted_merge u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Requests waiting for the driver, and merge results still to arrive.
    t_in_req pending_reqs[$];
    t_result merged_expect[$];
    int      fail_count;
    int      idle_pct;
    logic    hold_sender;

    // Shadow of the block's shared element store and per-list links.
    logic signed [31:0] shadow_vals[CAPACITY];
    int                 shadow_next[CAPACITY];
    int                 shadow_head[NUM_LISTS];
    int                 shadow_tail[NUM_LISTS];
    int                 shadow_count;
    logic               shadow_dropped;

    function automatic void shadow_clear();
        for (int l = 0; l < NUM_LISTS; l++) begin
            shadow_head[l] = NO_ELEM;
            shadow_tail[l] = NO_ELEM;
        end
        shadow_count   = 0;
        shadow_dropped = 1'b0;
    endfunction

    // Apply one accepted request to the shadow. An end request drains every
    // list in ascending order: the smallest head wins, ties to the lower list,
    // which is exactly what the hardware minimum scan is required to produce.
    function automatic void predict_merge(t_in_req r);
        int      best;
        int      idx;
        t_result res;
        int      n;
        if (r.kind == K_LOAD) begin
            if (shadow_count >= CAPACITY) begin
                shadow_dropped = 1'b1;
                return;
            end
            idx = shadow_count;
            shadow_vals[idx] = r.element_value;
            shadow_next[idx] = NO_ELEM;
            if (shadow_tail[r.list_id] == NO_ELEM)
                shadow_head[r.list_id] = idx;
            else
                shadow_next[shadow_tail[r.list_id]] = idx;
            shadow_tail[r.list_id] = idx;
            shadow_count++;
            return;
        end
        n = 0;
        forever begin
            best = -1;
            for (int l = 0; l < NUM_LISTS; l++) begin
                if (shadow_head[l] != NO_ELEM) begin
                    if (best < 0 ||
                        shadow_vals[shadow_head[l]] < shadow_vals[shadow_head[best]])
                        best = l;
                end
            end
            if (best < 0)
                break;
            idx = shadow_head[best];
            res.merged_value = shadow_vals[idx];
            res.source_list  = best[3:0];
            res.is_last      = 1'b0;
            res.overflowed   = shadow_dropped;
            merged_expect.push_back(res);
            shadow_head[best] = shadow_next[idx];
            n++;
        end
        if (n > 0)
            merged_expect[$].is_last = 1'b1;
        shadow_clear();
    endfunction

    // Driver: offers the head of the pending queue, with random idle gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (start && !busy) begin
                predict_merge(i_req);
                void'(pending_reqs.pop_front());
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_reqs.size() > 0 && !hold_sender &&
                         $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_req <= pending_reqs[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe must match the oldest expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (merged_expect.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, o_result);
                fail_count++;
            end else begin
                if (o_result !== merged_expect[0]) begin
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, merged_expect[0], o_result);
                    fail_count++;
                end
                void'(merged_expect.pop_front());
            end
        end
    end

    function automatic t_in_req mk_req(logic k, logic [3:0] l, logic [31:0] v);
        t_in_req r;
        r.kind          = k;
        r.list_id       = l;
        r.element_value = v;
        return r;
    endfunction

    // Wait until the driver has taken every queued request.
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || start)
            @(posedge i_clk);
    endtask

    // One load phase: a few ascending lists with random content, then end.
    // Occasionally the order is broken.
    task automatic queue_merge_run();
        int          n_elems;
        int          n_lists;
        logic [31:0] base[NUM_LISTS];
        logic [3:0]  l;
        logic [31:0] v;
        int          mode;
        mode    = $urandom_range(9);
        n_lists = $urandom_range(1, NUM_LISTS);
        n_elems = $urandom_range(1, 14);
        for (int i = 0; i < NUM_LISTS; i++)
            base[i] = (mode == 1) ? $urandom : 32'h8000_0000 + $urandom_range(1000);
        for (int i = 0; i < n_elems; i++) begin
            l = 4'($urandom_range(n_lists - 1));
            if (mode == 1) begin
                v = $urandom;
            end else if (mode == 2) begin
                v = $urandom_range(3);
            end else begin
                base[l] = base[l] + $urandom_range(1 << $urandom_range(28));
                if ($signed(base[l]) < 0 && $urandom_range(3) == 0)
                    base[l] = $urandom_range(50);
                v = base[l];
            end
            pending_reqs.push_back(mk_req(K_LOAD, l, v));
        end
        pending_reqs.push_back(mk_req(K_END, 4'($urandom), $urandom));
    endtask

    initial begin
        fail_count  = 0;
        idle_pct    = 0;
        hold_sender = 1'b0;
        i_rst_n     = 1'b0;
        shadow_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme values, ties across lists, an empty merge,
        // a merge with one element, and all-ones bits in every field.
        pending_reqs.push_back(mk_req(K_END, 4'hF, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd15, 32'h8000_0000));
        pending_reqs.push_back(mk_req(K_END, 4'd0, 32'd0));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd3, 32'd5));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd1, 32'd5));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd15, 32'h7FFF_FFFF));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd0, 32'h8000_0000));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd1, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd0, 32'd0));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd3, 32'd2));
        pending_reqs.push_back(mk_req(K_LOAD, 4'd8, 32'd5));
        pending_reqs.push_back(mk_req(K_END, 4'd0, 32'd0));
        // Fill past capacity to see the drop flag on every result.
        for (int i = 0; i < 66; i++)
            pending_reqs.push_back(mk_req(K_LOAD, i[3:0], i));
        pending_reqs.push_back(mk_req(K_END, 4'd0, 32'd0));

        // Random phases: no idling, sender idle 62 percent, no idling, then 31.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 62 : (ph == 3) ? 31 : 0;
            for (int r = 0; r < 2; r++)
                queue_merge_run();
            wait_drained();
            if (ph == 1) begin
                // Hold the sender until every result has come back.
                hold_sender = 1'b1;
                while (merged_expect.size() > 0)
                    @(posedge i_clk);
                repeat (100) @(posedge i_clk);
                hold_sender = 1'b0;
            end
        end
        wait_drained();
        while (merged_expect.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("k_way_sorted_merge regression: pass");
        else
            $display("k_way_sorted_merge regression: fail");
        $finish;
    end

    initial begin
        #30ms;
        $display("k_way_sorted_merge regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
hdl/kwm_pkg.sv
hdl/kwm_front.sv
hdl/kwm_back.sv
hdl/k_way_sorted_merge.sv
bench/tb.sv
